/* design/mq_pkg.sv */
// Package for the max queue: word types, payload structs, cell control and status codes.
package mq_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned CountW = $clog2(Depth + 1);

  typedef logic signed [31:0] mq_word_t;

  localparam logic ModePush = 1'b0;
  localparam logic ModePop  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY_POP = 2'd2
  } mq_status_e;

  typedef struct packed {
    logic     mode;
    mq_word_t value;
  } mq_in_t;

  typedef struct packed {
    mq_word_t   front_value;
    mq_word_t   queue_max;
    logic [4:0] count;
    logic       is_empty;
    mq_status_e status;
  } mq_out_t;

  // Per-cell control: shift towards the front, load a new entry, or raise the maximum.
  typedef struct packed {
    logic shift;
    logic load;
    logic raise;
  } mq_ctrl_t;

endpackage

/* design/mq_cell.sv */
// One storage cell of the max queue, holding an entry and the maximum of it and all behind it.
module mq_cell (
  input  logic             clk_i,
  input  mq_pkg::mq_ctrl_t ctrl_i,
  input  mq_pkg::mq_word_t push_value_i,
  input  mq_pkg::mq_word_t next_value_i,
  input  mq_pkg::mq_word_t next_max_i,
  output mq_pkg::mq_word_t value_o,
  output mq_pkg::mq_word_t max_o
);

  mq_pkg::mq_word_t value_q, value_d;
  mq_pkg::mq_word_t max_q, max_d;

  always_comb begin
    value_d = value_q;
    max_d   = max_q;
    if (ctrl_i.shift) begin
      value_d = next_value_i;
      max_d   = next_max_i;
    end else if (ctrl_i.load) begin
      value_d = push_value_i;
      max_d   = push_value_i;
    end else if (ctrl_i.raise && (max_q < push_value_i)) begin
      max_d = push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    max_q   <= max_d;
  end

  assign value_o = value_q;
  assign max_o   = max_q;

endmodule

/* design/max_queue.sv */
// Top level of the max queue: a row of cells with the front at cell zero, and the handshakes.
// The queue holds up to 16 signed 32-bit words in a row of cells, the front word always in the
// first cell; a pop shifts every cell one place towards the front, a push loads the first free
// cell and raises the running maximum of every occupied cell in the same cycle, and a new word
// is taken in every cycle while results are being taken.
// Each word gives exactly one result, held in an output register until it is accepted; the
// queue maximum is the maximum kept in the front cell.
module max_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mq_pkg::mq_in_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mq_pkg::mq_out_t out_data_o
);

  logic [mq_pkg::CountW-1:0] count_q, count_d;
  mq_pkg::mq_status_e        status_q, status_d;
  logic                      out_valid_q, out_valid_d;

  logic accept, is_push, full, empty, do_push, do_pop;

  mq_pkg::mq_word_t cell_value [mq_pkg::Depth];
  mq_pkg::mq_word_t cell_max   [mq_pkg::Depth];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_push    = (in_data_i.mode == mq_pkg::ModePush);
  assign full       = (count_q == mq_pkg::CountW'(mq_pkg::Depth));
  assign empty      = (count_q == '0);
  assign do_push    = accept && is_push && !full;
  assign do_pop     = accept && !is_push && !empty;

  for (genvar i = 0; i < mq_pkg::Depth; i++) begin : g_cell
    mq_pkg::mq_ctrl_t ctrl;
    mq_pkg::mq_word_t next_value, next_max;

    assign ctrl.shift = do_pop;
    assign ctrl.load  = do_push && (count_q == mq_pkg::CountW'(i));
    assign ctrl.raise = do_push && (mq_pkg::CountW'(i) < count_q);

    if (i == mq_pkg::Depth - 1) begin : g_last
      assign next_value = '0;
      assign next_max   = '0;
    end else begin : g_inner
      assign next_value = cell_value[i+1];
      assign next_max   = cell_max[i+1];
    end

    mq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .push_value_i (in_data_i.value),
      .next_value_i (next_value),
      .next_max_i   (next_max),
      .value_o      (cell_value[i]),
      .max_o        (cell_max[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = mq_pkg::ST_DONE;
      if (is_push) begin
        if (full) begin
          status_d = mq_pkg::ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end else begin
        if (empty) begin
          status_d = mq_pkg::ST_EMPTY_POP;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      status_q    <= mq_pkg::ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.front_value  = empty ? '0 : cell_value[0];
  assign out_data_o.queue_max    = empty ? '0 : cell_max[0];
  assign out_data_o.count        = 5'(count_q);
  assign out_data_o.is_empty     = empty;
  assign out_data_o.status       = status_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mq_pkg::CountW'(mq_pkg::Depth))
    else $error("Entry count exceeds the queue depth.");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_push && full) |=>
      (status_q == mq_pkg::ST_FULL) && $stable(count_q) && out_valid_q)
    else $error("A push to a full queue was not refused.");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> (count_q == $past(count_q) - 1'b1) && (status_q == mq_pkg::ST_DONE))
    else $error("A pop did not remove exactly one entry.");

  a_front_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !empty) |-> (cell_max[0] >= cell_value[0]))
    else $error("The queue maximum is below the front word.");
`endif

endmodule
